// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define SPF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the default clock and reset names.
`define SPF_ASSERT(label, prop, msg) `SPF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/spf_pkg.sv =====
// Types and fixed widths of the suffix period finder.
`default_nettype none

package spf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned PERIOD_W = 6;
  localparam int unsigned RUN_W    = 6;

  localparam logic [CFG_W-1:0] MIN_RUN_RESET = 7'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAG,
    ST_READ,
    ST_CMP,
    ST_REPORT,
    ST_PUSH,
    ST_MARK,
    ST_FLUSH
  } spf_state_e;

endpackage

`default_nettype wire

// ===== hdl/spf_in_if.sv =====
// Input channel carrying one text byte per transfer.
`default_nettype none

interface spf_in_if;
  logic                       valid;
  logic                       ready;
  logic [spf_pkg::BYTE_W-1:0] text_byte;
  logic                       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== hdl/spf_out_if.sv =====
// Output channel carrying one reported period per transfer.
`default_nettype none

interface spf_out_if;
  logic                         valid;
  logic                         ready;
  logic [spf_pkg::PERIOD_W-1:0] period;
  logic [spf_pkg::RUN_W-1:0]    run_length;
  logic                         truncated;
  logic                         last_result;

  modport source (output valid, output period, output run_length, output truncated,
                  output last_result, input ready);
  modport sink   (input valid, input period, input run_length, input truncated,
                  input last_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/suffix_period_finder_unit.sv =====
// Top level of the suffix period finder: text buffer, lag sequencer and result register.
`default_nettype none

// Bytes are loaded at one per cycle into a MAX_LEN-entry buffer; beyond MAX_LEN the oldest
// bytes are overwritten and results carry the truncated flag. The transfer marked
// end_of_text starts the analysis, during which the input is not ready. Each candidate lag
// is first checked against the skip marks. A lag that is not skipped then reads and compares
// byte pairs (the buffer has two read ports with registered data, so every compare waits for
// its read), takes one more read when the run reaches the start of the buffer, judges the
// run, moves the previous result to the output register when the lag is reported and an
// earlier result is still held, and sets its skip marks one at a time; a final step hands
// over the last result. Output stalls lengthen both hand-over steps. For n loaded bytes at
// most about n*n/2 byte pairs are compared. Results leave through an output register, and
// the final one carries last_result; when no lag qualifies, a single result with period 0
// is sent.
module suffix_period_finder_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [spf_pkg::CFG_W-1:0]   cfg_wdata_i,
  spf_in_if.sink                           text_i,
  spf_out_if.source                        result_o
);
  import spf_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = AW + 1;

  spf_state_e state_q, state_d;

  logic [CFG_W-1:0]  min_run_q;
  logic [BYTE_W-1:0] mem_q [MAX_LEN];
  logic [BYTE_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]     wp_q;
  logic [CW-1:0]     cnt_q;
  logic              ovf_q;
  logic [MAX_LEN-1:0] skip_q;
  logic [CW-1:0]     w_q, run_q, m_q;
  logic              pend_vld_q;
  logic [CW-1:0]     pend_per_q, pend_run_q;

  logic              out_vld_q;
  logic [PERIOD_W-1:0] out_per_q;
  logic [RUN_W-1:0]  out_run_q;
  logic              out_trunc_q, out_last_q;

  logic          in_fire, out_free;
  logic          lag_open, lag_skip, rd_more, same, hit, mark_go, mark_more;
  logic [CW-1:0] run_w, m_next;
  logic [AW-1:0] addr_a, addr_b;

  // Control strobes from the sequencer.
  logic in_ready, start, w_step, run_inc, ld_pend, ld_out_mid, ld_out_end, set_skip;

  // Buffer slot holding the byte at a given distance back from the newest one.
  function automatic logic [AW-1:0] tail_addr(input logic [AW-1:0] wp,
                                               input logic [CW-1:0] back);
    logic [CW-1:0] t;
    t = {1'b0, wp} + CW'(MAX_LEN - 1) - back;
    if (t >= CW'(MAX_LEN)) begin
      t = t - CW'(MAX_LEN);
    end
    return t[AW-1:0];
  endfunction

  assign in_fire  = text_i.valid && text_i.ready;
  assign out_free = !out_vld_q || result_o.ready;

  assign run_w     = run_q + w_q;
  assign lag_open  = w_q < cnt_q;
  assign lag_skip  = skip_q[w_q[AW-1:0]];
  assign rd_more   = run_w < cnt_q;
  assign same      = rd_a_q == rd_b_q;
  assign hit       = CFG_W'(run_q) >= min_run_q;
  assign mark_go   = w_q < run_q;
  assign m_next    = m_q + w_q;
  assign mark_more = m_next < run_w;

  assign addr_a = tail_addr(wp_q, run_q);
  assign addr_b = tail_addr(wp_q, run_w);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && text_i.end_of_text) state_d = ST_LAG;
      end
      ST_LAG: begin
        if (!lag_open) state_d = ST_FLUSH;
        else if (!lag_skip) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = rd_more ? ST_CMP : ST_REPORT;
      end
      ST_CMP: begin
        state_d = same ? ST_READ : ST_REPORT;
      end
      ST_REPORT: begin
        if (hit && pend_vld_q) state_d = ST_PUSH;
        else state_d = mark_go ? ST_MARK : ST_LAG;
      end
      ST_PUSH: begin
        if (out_free) state_d = mark_go ? ST_MARK : ST_LAG;
      end
      ST_MARK: begin
        if (!mark_more) state_d = ST_LAG;
      end
      ST_FLUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    start      = 1'b0;
    w_step     = 1'b0;
    run_inc    = 1'b0;
    ld_pend    = 1'b0;
    ld_out_mid = 1'b0;
    ld_out_end = 1'b0;
    set_skip   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        start    = in_fire && text_i.end_of_text;
      end
      ST_LAG: begin
        w_step = lag_open && lag_skip;
      end
      ST_CMP: begin
        run_inc = same;
      end
      ST_REPORT: begin
        ld_pend = hit && !pend_vld_q;
        w_step  = !(hit && pend_vld_q) && !mark_go;
      end
      ST_PUSH: begin
        ld_pend    = out_free;
        ld_out_mid = out_free;
        w_step     = out_free && !mark_go;
      end
      ST_MARK: begin
        set_skip = 1'b1;
        w_step   = !mark_more;
      end
      ST_FLUSH: begin
        ld_out_end = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign text_i.ready = in_ready;

  // Text buffer with two registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem_q[wp_q] <= text_i.text_byte;
    end
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      min_run_q  <= MIN_RUN_RESET;
      wp_q       <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      skip_q     <= '0;
      w_q        <= '0;
      run_q      <= '0;
      m_q        <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        min_run_q <= cfg_wdata_i;
      end

      if (in_fire) begin
        wp_q <= (wp_q == AW'(MAX_LEN - 1)) ? '0 : wp_q + AW'(1);
        if (cnt_q < CW'(MAX_LEN)) cnt_q <= cnt_q + CW'(1);
        else ovf_q <= 1'b1;
      end

      if (start) begin
        skip_q <= '0;
        w_q    <= CW'(1);
      end else if (w_step) begin
        w_q <= w_q + CW'(1);
      end

      if (state_q == ST_LAG) run_q <= '0;
      else if (run_inc) run_q <= run_q + CW'(1);

      // The first multiple to mark is twice the lag.
      if (state_q == ST_REPORT || state_q == ST_PUSH) m_q <= w_q + w_q;
      else if (set_skip) m_q <= m_next;

      if (set_skip && (m_q < CW'(MAX_LEN))) begin
        skip_q[m_q[AW-1:0]] <= 1'b1;
      end

      if (ld_pend) begin
        pend_vld_q <= 1'b1;
      end else if (ld_out_end) begin
        pend_vld_q <= 1'b0;
      end

      if (ld_out_mid || ld_out_end) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end

      if (ld_out_end) begin
        wp_q  <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (ld_pend) begin
      pend_per_q <= w_q;
      pend_run_q <= run_q;
    end
    if (ld_out_mid || ld_out_end) begin
      out_trunc_q <= ovf_q;
      out_last_q  <= ld_out_end;
      if (ld_out_end && !pend_vld_q) begin
        out_per_q <= '0;
        out_run_q <= '0;
      end else begin
        out_per_q <= PERIOD_W'(pend_per_q);
        out_run_q <= RUN_W'(pend_run_q);
      end
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.period      = out_per_q;
  assign result_o.run_length  = out_run_q;
  assign result_o.truncated   = out_trunc_q;
  assign result_o.last_result = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/spf_checker.sv =====
// Port-level checks of the suffix period finder and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"

module spf_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          in_end_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [spf_pkg::PERIOD_W-1:0]  out_period_i,
  input wire logic [spf_pkg::RUN_W-1:0]     out_run_i,
  input wire logic                          out_last_i
);
  import spf_pkg::*;

  // A result that is not taken stays offered.
  `SPF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")

  // The final byte starts an analysis, so the next byte must wait.
  `SPF_ASSERT(a_busy_after_end, in_valid_i && in_ready_i && in_end_i |=> !in_ready_i, "input ready during analysis")

  // A byte that is not final only loads the buffer and keeps the input open.
  `SPF_ASSERT(a_load_keeps_ready, in_valid_i && in_ready_i && !in_end_i |=> in_ready_i, "input stalled while loading")

  // The none marker is the only result of its analysis and carries no run.
  `SPF_ASSERT(a_none_marker, out_valid_i && (out_period_i == '0) |-> out_last_i && (out_run_i == '0), "malformed none marker")

endmodule

bind suffix_period_finder_unit spf_checker u_spf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (text_i.valid),
  .in_ready_i   (text_i.ready),
  .in_end_i     (text_i.end_of_text),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_period_i (result_o.period),
  .out_run_i    (result_o.run_length),
  .out_last_i   (result_o.last_result)
);

`default_nettype wire
